// ===== rtl/core/trwd_pkg.sv =====
// ----------------------------------------------------------------------------
// trwd_pkg: shared definitions for the transfer rate watchdog
// Field widths, event kinds, register indexes, datapath operations and the
// status bundle returned from the datapath to the controller.
// ----------------------------------------------------------------------------
package trwd_pkg;

    localparam int MAX_WINDOW_DEF = 64;

    localparam int TICK_W  = 40;
    localparam int BYTES_W = 24;
    localparam int SEC_W   = 24;
    localparam int TOTAL_W = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 48;

    localparam logic [SEC_W-1:0] SEC_NONE = 24'hFFFFFF;
    localparam logic [SEC_W-1:0] SEC_MAX  = 24'hFFFFFE;

    localparam int TICKS_PER_SECOND = 100;
    localparam int LAST_CHUNK_GRACE = 400;
    localparam int DIV_STEPS        = 40;

    // Tick differences at or above this value give the saturated second count.
    localparam logic [39:0] SEC_SAT_TICKS = 40'd1677721500;
    // Reciprocal of 25 scaled by 2^34; exact while the tick count divided by four is below 2^29.
    localparam logic [29:0] SEC_RECIP     = 30'd687194768;

    localparam logic [6:0]  WINDOW_RESET      = 7'd30;
    localparam logic [23:0] MIN_RATE_RESET    = 24'd7000;
    localparam logic [15:0] REPLY_DELAY_RESET = 16'd60;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW      = 2'd0;
    localparam logic [1:0] CFG_MIN_RATE    = 2'd1;
    localparam logic [1:0] CFG_REPLY_DELAY = 2'd2;

    // Event kinds.
    localparam logic [2:0] KIND_SENT      = 3'd0;
    localparam logic [2:0] KIND_RECV      = 3'd1;
    localparam logic [2:0] KIND_UP_START  = 3'd2;
    localparam logic [2:0] KIND_UP_END    = 3'd3;
    localparam logic [2:0] KIND_REDIRECT  = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;
    localparam logic [2:0] KIND_MAYBE_END = 3'd6;

    typedef logic [4:0] op_t;

    // Datapath operations.
    localparam op_t OP_NONE     = 5'd0;
    localparam op_t OP_LOAD     = 5'd1;
    localparam op_t OP_PHASE    = 5'd2;
    localparam op_t OP_DIV      = 5'd3;
    localparam op_t OP_SEC      = 5'd4;
    localparam op_t OP_SAME_WR  = 5'd5;
    localparam op_t OP_ZRD      = 5'd6;
    localparam op_t OP_ZWR      = 5'd7;
    localparam op_t OP_ADV      = 5'd8;
    localparam op_t OP_MOD_DONE = 5'd9;
    localparam op_t OP_FIN_RD   = 5'd10;
    localparam op_t OP_FIN_WR   = 5'd11;
    localparam op_t OP_EVAL     = 5'd12;
    localparam op_t OP_SRD      = 5'd13;
    localparam op_t OP_SWR      = 5'd14;
    localparam op_t OP_STALL    = 5'd15;
    localparam op_t OP_OUT      = 5'd16;
    localparam op_t OP_SCALE    = 5'd17;

    typedef struct packed {
        logic measure;
        logic first;
        logic same;
        logic steps_nz;
        logic zmore;
        logic extra_zero;
        logic abort_cond;
        logic total_ge;
        logic smore;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/trwd_ram.sv =====
// ----------------------------------------------------------------------------
// trwd_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module trwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/trwd_dp.sv =====
// ----------------------------------------------------------------------------
// trwd_dp: watchdog datapath
// Holds configuration, phase flags, window state, the byte bucket store, a
// reciprocal multiplier for the seconds count and a shift-subtract divider
// for the bucket wrap; executes one operation per cycle.
// ----------------------------------------------------------------------------
module trwd_dp #(
    parameter int MAX_WINDOW = trwd_pkg::MAX_WINDOW_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  trwd_pkg::op_t             op,
    input  logic [trwd_pkg::IN_W-1:0] s_tdata,
    input  logic [2:0]                s_tuser,
    input  logic                      s_tlast,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [23:0]               cfg_data,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [trwd_pkg::OUT_W-1:0] m_tdata,
    output trwd_pkg::status_t         status
);

    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DW  = (WW > 7) ? WW : 7;
    localparam int MTW = 24 + WW;
    localparam int CW  = (MTW > 32) ? MTW : 32;
    localparam int MSW = 27;

    // Configuration.
    logic [6:0]  win_sec_reg, win_sec_next;
    logic [23:0] min_rate_reg, min_rate_next;
    logic [15:0] reply_delay_reg, reply_delay_next;

    // Latched item.
    logic [2:0]  kind_reg, kind_next;
    logic [39:0] now_reg, now_next;
    logic [23:0] bytes_reg, bytes_next;
    logic        fin_reg, fin_next;

    // Watchdog state.
    logic [39:0]           window_start_reg, window_start_next;
    logic                  monitor_on_reg, monitor_on_next;
    logic                  final_seen_reg, final_seen_next;
    logic [23:0]           prev_sec_reg, prev_sec_next;
    logic [39:0]           stall_time_reg, stall_time_next;
    logic                  stall_valid_reg, stall_valid_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [23:0]           refill_reg, refill_next;
    logic [31:0]           total_reg, total_next;
    logic                  awaiting_reg, awaiting_next;
    logic                  upload_done_reg, upload_done_next;
    logic [MAX_WINDOW-1:0] vld_reg, vld_next;

    // Working registers.
    logic [23:0]           sec_reg, sec_next;
    logic [AW-1:0]         b_reg, b_next;
    logic [23:0]           s_reg, s_next;
    logic [WW-1:0]         steps_reg, steps_next;
    logic [23:0]           extra_reg, extra_next;
    logic [MTW-1:0]        mintotal_reg, mintotal_next;
    logic [31:0]           tb_reg, tb_next;
    logic [WW-1:0]         idx_reg, idx_next;
    logic signed [MSW-1:0] maxst_reg, maxst_next;
    logic                  abort_reg, abort_next;
    logic                  closed_reg, closed_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [39:0]           quo_reg, quo_next;
    logic [DW-1:0]         dvsr_reg, dvsr_next;
    logic                  rd_vld_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [trwd_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // Bucket RAM port.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [31:0]   rd_eff;

    // Helpers.
    logic [WW-1:0]  w_eff;
    logic [23:0]    sec_c;
    logic [AW-1:0]  cur_eff;
    logic [AW-1:0]  b_adv;
    logic [23:0]    gm1;
    logic [DW:0]    div_t;
    logic [CW-1:0]  total_x;
    logic [CW-1:0]  mintotal_x;
    logic [31:0]    tb_c;
    logic [WW-1:0]  idx_c;
    logic [24:0]    refill_sum;
    logic [39:0]    close_deadline;
    logic signed [39:0] maxst_ticks;
    logic [58:0]    sec_prod;

    // Phase event decode.
    logic ph_close;
    logic ph_restart;
    logic ph_measure;

    trwd_ram #(
        .WIDTH (trwd_pkg::TOTAL_W),
        .DEPTH (MAX_WINDOW)
    ) u_buckets (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (win_sec_reg == 7'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(win_sec_reg) > 32'(MAX_WINDOW))
        begin
            w_eff = WW'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WW'(win_sec_reg);
        end
    end

    assign sec_c   = (quo_reg > 40'(trwd_pkg::SEC_MAX)) ? trwd_pkg::SEC_MAX : quo_reg[23:0];
    assign cur_eff = (32'(cur_reg) < 32'(MAX_WINDOW)) ? cur_reg : '0;
    assign b_adv   = ((WW + 1)'(b_reg) + (WW + 1)'(1) >= (WW + 1)'(w_eff)) ?
                     '0 : AW'((WW + 1)'(b_reg) + (WW + 1)'(1));
    assign gm1     = sec_c - prev_sec_reg - 24'd1;
    assign div_t   = {rem_reg, quo_reg[39]};
    assign rd_eff  = rd_vld_reg ? ram_rdata : 32'd0;
    assign total_x    = CW'(total_reg);
    assign mintotal_x = CW'(mintotal_reg);
    assign tb_c       = tb_reg - rd_eff;
    assign idx_c      = idx_reg + WW'(1);
    assign refill_sum = 25'(sec_c) + 25'(w_eff);
    assign close_deadline = now_reg + 40'(reply_delay_reg) * 40'(trwd_pkg::TICKS_PER_SECOND);
    assign maxst_ticks    = 40'(maxst_reg) * 40'sd100;
    // Seconds are the tick count divided by four, then by 25.
    assign sec_prod       = 59'(quo_reg[30:2]) * 59'(trwd_pkg::SEC_RECIP);

    always_comb
    begin
        ph_close   = 1'b0;
        ph_restart = 1'b0;
        ph_measure = 1'b0;
        case (kind_reg)
            trwd_pkg::KIND_SENT:
            begin
                ph_restart = !monitor_on_reg;
                ph_measure = 1'b1;
            end
            trwd_pkg::KIND_RECV:
            begin
                if (awaiting_reg && (bytes_reg != 24'd0))
                begin
                    ph_close   = !upload_done_reg;
                    ph_restart = 1'b1;
                    ph_measure = 1'b1;
                end
                else
                begin
                    ph_measure = monitor_on_reg;
                end
            end
            trwd_pkg::KIND_UP_START:
            begin
                ph_restart = 1'b1;
            end
            trwd_pkg::KIND_UP_END:
            begin
                ph_close = !upload_done_reg;
            end
            trwd_pkg::KIND_MAYBE_END:
            begin
                ph_close = !upload_done_reg && final_seen_reg;
            end
            default:
            begin
                ph_close = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        win_sec_next      = win_sec_reg;
        min_rate_next     = min_rate_reg;
        reply_delay_next  = reply_delay_reg;
        kind_next         = kind_reg;
        now_next          = now_reg;
        bytes_next        = bytes_reg;
        fin_next          = fin_reg;
        window_start_next = window_start_reg;
        monitor_on_next   = monitor_on_reg;
        final_seen_next   = final_seen_reg;
        prev_sec_next     = prev_sec_reg;
        stall_time_next   = stall_time_reg;
        stall_valid_next  = stall_valid_reg;
        cur_next          = cur_reg;
        refill_next       = refill_reg;
        total_next        = total_reg;
        awaiting_next     = awaiting_reg;
        upload_done_next  = upload_done_reg;
        vld_next          = vld_reg;
        sec_next          = sec_reg;
        b_next            = b_reg;
        s_next            = s_reg;
        steps_next        = steps_reg;
        extra_next        = extra_reg;
        mintotal_next     = mintotal_reg;
        tb_next           = tb_reg;
        idx_next          = idx_reg;
        maxst_next        = maxst_reg;
        abort_next        = abort_reg;
        closed_next       = closed_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        dvsr_next         = dvsr_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        ram_we            = 1'b0;
        ram_addr          = b_reg;
        ram_wdata         = 32'(bytes_reg);

        if (cfg_valid)
        begin
            case (cfg_index)
                trwd_pkg::CFG_WINDOW:      win_sec_next     = cfg_data[6:0];
                trwd_pkg::CFG_MIN_RATE:    min_rate_next    = cfg_data;
                trwd_pkg::CFG_REPLY_DELAY: reply_delay_next = cfg_data[15:0];
                default:                   win_sec_next     = win_sec_reg;
            endcase
        end

        case (op)
            trwd_pkg::OP_LOAD:
            begin
                kind_next   = s_tuser;
                now_next    = s_tdata[39:0];
                bytes_next  = s_tdata[63:40];
                fin_next    = s_tlast;
                abort_next  = 1'b0;
                closed_next = 1'b0;
            end
            trwd_pkg::OP_PHASE:
            begin
                if (kind_reg == trwd_pkg::KIND_UP_START)
                begin
                    upload_done_next = 1'b0;
                end
                if (kind_reg == trwd_pkg::KIND_DONE)
                begin
                    monitor_on_next  = 1'b0;
                    stall_valid_next = 1'b0;
                end
                if (kind_reg == trwd_pkg::KIND_RECV && ph_restart)
                begin
                    awaiting_next = 1'b0;
                end
                if (ph_close)
                begin
                    upload_done_next = 1'b1;
                    monitor_on_next  = 1'b0;
                    stall_time_next  = close_deadline;
                    stall_valid_next = 1'b1;
                    closed_next      = (kind_reg == trwd_pkg::KIND_MAYBE_END);
                end
                if (ph_restart)
                begin
                    window_start_next = now_reg;
                    monitor_on_next   = 1'b1;
                    final_seen_next   = 1'b0;
                    prev_sec_next     = trwd_pkg::SEC_NONE;
                    stall_valid_next  = 1'b0;
                end
                if (ph_measure)
                begin
                    final_seen_next = (kind_reg == trwd_pkg::KIND_SENT) && fin_reg;
                    quo_next  = ph_restart ? 40'd0 : (now_reg - window_start_reg);
                end
            end
            trwd_pkg::OP_SCALE:
            begin
                if (quo_reg >= trwd_pkg::SEC_SAT_TICKS)
                begin
                    quo_next = 40'(trwd_pkg::SEC_MAX);
                end
                else
                begin
                    quo_next = 40'(sec_prod[58:34]);
                end
            end
            trwd_pkg::OP_DIV:
            begin
                if (div_t >= {1'b0, dvsr_reg})
                begin
                    rem_next = DW'(div_t - {1'b0, dvsr_reg});
                    quo_next = {quo_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_next = div_t[DW-1:0];
                    quo_next = {quo_reg[38:0], 1'b0};
                end
            end
            trwd_pkg::OP_SEC:
            begin
                sec_next      = sec_c;
                mintotal_next = MTW'(min_rate_reg) * MTW'(w_eff);
                if (prev_sec_reg == trwd_pkg::SEC_NONE)
                begin
                    cur_next      = '0;
                    refill_next   = refill_sum[24] ? trwd_pkg::SEC_NONE : refill_sum[23:0];
                    total_next    = 32'(bytes_reg);
                    prev_sec_next = sec_c;
                    ram_we        = 1'b1;
                    ram_addr      = '0;
                    vld_next[0]   = 1'b1;
                end
                else if (sec_c <= prev_sec_reg)
                begin
                    ram_addr = cur_eff;
                end
                else
                begin
                    if (32'(gm1) > 32'(w_eff))
                    begin
                        steps_next = w_eff;
                        extra_next = gm1 - 24'(w_eff);
                    end
                    else
                    begin
                        steps_next = WW'(gm1);
                        extra_next = 24'd0;
                    end
                    b_next = cur_eff;
                    s_next = prev_sec_reg;
                end
            end
            trwd_pkg::OP_SAME_WR:
            begin
                total_next        = total_reg + 32'(bytes_reg);
                ram_we            = 1'b1;
                ram_addr          = cur_eff;
                ram_wdata         = rd_eff + 32'(bytes_reg);
                vld_next[cur_eff] = 1'b1;
            end
            trwd_pkg::OP_ZRD:
            begin
                b_next     = b_adv;
                s_next     = s_reg + 24'd1;
                steps_next = steps_reg - WW'(1);
                ram_addr   = b_adv;
            end
            trwd_pkg::OP_ZWR:
            begin
                // Zeroing a bucket drops its valid bit; from the refill second on, its bytes also leave the total.
                if (s_reg >= refill_reg)
                begin
                    total_next = total_reg - rd_eff;
                end
                vld_next[b_reg] = 1'b0;
            end
            trwd_pkg::OP_ADV:
            begin
                if (extra_reg == 24'd0)
                begin
                    b_next = b_adv;
                end
                else
                begin
                    rem_next  = '0;
                    quo_next  = 40'(b_adv) + 40'(extra_reg);
                    dvsr_next = DW'(w_eff);
                end
            end
            trwd_pkg::OP_MOD_DONE:
            begin
                b_next = AW'(rem_reg);
            end
            trwd_pkg::OP_FIN_RD:
            begin
                ram_addr = b_reg;
            end
            trwd_pkg::OP_FIN_WR:
            begin
                total_next = total_reg - ((sec_reg >= refill_reg) ? rd_eff : 32'd0)
                             + 32'(bytes_reg);
                ram_we          = 1'b1;
                ram_addr        = b_reg;
                vld_next[b_reg] = 1'b1;
                cur_next        = b_reg;
                prev_sec_next   = sec_reg;
            end
            trwd_pkg::OP_EVAL:
            begin
                if (status.abort_cond)
                begin
                    if (final_seen_reg)
                    begin
                        stall_time_next  = now_reg + 40'(trwd_pkg::LAST_CHUNK_GRACE);
                        stall_valid_next = 1'b1;
                    end
                    else
                    begin
                        abort_next = 1'b1;
                    end
                end
                else if (status.total_ge)
                begin
                    tb_next    = total_reg;
                    idx_next   = '0;
                    maxst_next = $signed(MSW'(refill_reg)) - $signed(MSW'(sec_reg))
                                 - MSW'(1);
                end
                else
                begin
                    maxst_next = $signed(MSW'(w_eff)) - $signed(MSW'(sec_reg));
                end
            end
            trwd_pkg::OP_SRD:
            begin
                ram_addr = idx_reg[AW-1:0];
            end
            trwd_pkg::OP_SWR:
            begin
                maxst_next = maxst_reg + MSW'(1);
                tb_next    = tb_c;
                idx_next   = idx_c;
            end
            trwd_pkg::OP_STALL:
            begin
                stall_time_next  = now_reg + 40'(maxst_ticks);
                stall_valid_next = 1'b1;
            end
            trwd_pkg::OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = {5'd0, closed_reg,
                                  stall_valid_reg ? stall_time_reg : 40'd0,
                                  stall_valid_reg, abort_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        status.measure    = ph_measure;
        status.first      = (prev_sec_reg == trwd_pkg::SEC_NONE);
        status.same       = (prev_sec_reg != trwd_pkg::SEC_NONE) && (sec_c <= prev_sec_reg);
        status.steps_nz   = (gm1 != 24'd0);
        status.zmore      = (steps_reg != '0);
        status.extra_zero = (extra_reg == 24'd0);
        status.abort_cond = (32'(sec_reg) >= 32'(w_eff)) && (total_x < mintotal_x);
        status.total_ge   = (total_x >= mintotal_x);
        status.smore      = (CW'(tb_c) >= mintotal_x) && (idx_c < w_eff);
        status.out_free   = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_sec_reg      <= trwd_pkg::WINDOW_RESET;
            min_rate_reg     <= trwd_pkg::MIN_RATE_RESET;
            reply_delay_reg  <= trwd_pkg::REPLY_DELAY_RESET;
            kind_reg         <= '0;
            now_reg          <= '0;
            bytes_reg        <= '0;
            fin_reg          <= 1'b0;
            window_start_reg <= '0;
            monitor_on_reg   <= 1'b0;
            final_seen_reg   <= 1'b0;
            prev_sec_reg     <= trwd_pkg::SEC_NONE;
            stall_time_reg   <= '0;
            stall_valid_reg  <= 1'b0;
            cur_reg          <= '0;
            refill_reg       <= '0;
            total_reg        <= '0;
            awaiting_reg     <= 1'b1;
            upload_done_reg  <= 1'b0;
            vld_reg          <= '0;
            sec_reg          <= '0;
            b_reg            <= '0;
            s_reg            <= '0;
            steps_reg        <= '0;
            extra_reg        <= '0;
            mintotal_reg     <= '0;
            tb_reg           <= '0;
            idx_reg          <= '0;
            maxst_reg        <= '0;
            abort_reg        <= 1'b0;
            closed_reg       <= 1'b0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            dvsr_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            win_sec_reg      <= win_sec_next;
            min_rate_reg     <= min_rate_next;
            reply_delay_reg  <= reply_delay_next;
            kind_reg         <= kind_next;
            now_reg          <= now_next;
            bytes_reg        <= bytes_next;
            fin_reg          <= fin_next;
            window_start_reg <= window_start_next;
            monitor_on_reg   <= monitor_on_next;
            final_seen_reg   <= final_seen_next;
            prev_sec_reg     <= prev_sec_next;
            stall_time_reg   <= stall_time_next;
            stall_valid_reg  <= stall_valid_next;
            cur_reg          <= cur_next;
            refill_reg       <= refill_next;
            total_reg        <= total_next;
            awaiting_reg     <= awaiting_next;
            upload_done_reg  <= upload_done_next;
            vld_reg          <= vld_next;
            sec_reg          <= sec_next;
            b_reg            <= b_next;
            s_reg            <= s_next;
            steps_reg        <= steps_next;
            extra_reg        <= extra_next;
            mintotal_reg     <= mintotal_next;
            tb_reg           <= tb_next;
            idx_reg          <= idx_next;
            maxst_reg        <= maxst_next;
            abort_reg        <= abort_next;
            closed_reg       <= closed_next;
            rem_reg          <= rem_next;
            quo_reg          <= quo_next;
            dvsr_reg         <= dvsr_next;
            rd_vld_reg       <= vld_reg[ram_addr];
            out_valid_reg    <= out_valid_next;
            out_data_reg     <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/trwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// trwd_ctrl: watchdog controller
// Sequences the datapath through phase handling, the seconds scaling, the
// bucket skip and refill, the stall search and the result hand-off.
// ----------------------------------------------------------------------------
module trwd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  trwd_pkg::status_t status,
    output trwd_pkg::op_t     op
);

    localparam int CNTW = $clog2(trwd_pkg::DIV_STEPS);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_PHASE    = 5'd1;
    localparam logic [4:0] S_DIV      = 5'd2;
    localparam logic [4:0] S_SEC      = 5'd3;
    localparam logic [4:0] S_SAME     = 5'd4;
    localparam logic [4:0] S_ZRD      = 5'd5;
    localparam logic [4:0] S_ZWR      = 5'd6;
    localparam logic [4:0] S_ADV      = 5'd7;
    localparam logic [4:0] S_MOD      = 5'd8;
    localparam logic [4:0] S_MOD_DONE = 5'd9;
    localparam logic [4:0] S_FRD      = 5'd10;
    localparam logic [4:0] S_FWR      = 5'd11;
    localparam logic [4:0] S_EVAL     = 5'd12;
    localparam logic [4:0] S_SRD      = 5'd13;
    localparam logic [4:0] S_SWR      = 5'd14;
    localparam logic [4:0] S_STALL    = 5'd15;
    localparam logic [4:0] S_OUT      = 5'd16;

    logic [4:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            div_last;

    assign s_tready = (state_reg == S_IDLE);
    assign div_last = (cnt_reg == CNTW'(trwd_pkg::DIV_STEPS - 1));
    assign cnt_next = (state_reg == S_MOD) ? cnt_reg + CNTW'(1) : '0;

    always_comb
    begin
        state_next = state_reg;
        op         = trwd_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = trwd_pkg::OP_LOAD;
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                op         = trwd_pkg::OP_PHASE;
                state_next = status.measure ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                op         = trwd_pkg::OP_SCALE;
                state_next = S_SEC;
            end
            S_SEC:
            begin
                op = trwd_pkg::OP_SEC;
                if (status.first)
                begin
                    state_next = S_OUT;
                end
                else if (status.same)
                begin
                    state_next = S_SAME;
                end
                else
                begin
                    state_next = status.steps_nz ? S_ZRD : S_ADV;
                end
            end
            S_SAME:
            begin
                op         = trwd_pkg::OP_SAME_WR;
                state_next = S_OUT;
            end
            S_ZRD:
            begin
                op         = trwd_pkg::OP_ZRD;
                state_next = S_ZWR;
            end
            S_ZWR:
            begin
                op         = trwd_pkg::OP_ZWR;
                state_next = status.zmore ? S_ZRD : S_ADV;
            end
            S_ADV:
            begin
                op         = trwd_pkg::OP_ADV;
                state_next = status.extra_zero ? S_FRD : S_MOD;
            end
            S_MOD:
            begin
                op = trwd_pkg::OP_DIV;
                if (div_last)
                begin
                    state_next = S_MOD_DONE;
                end
            end
            S_MOD_DONE:
            begin
                op         = trwd_pkg::OP_MOD_DONE;
                state_next = S_FRD;
            end
            S_FRD:
            begin
                op         = trwd_pkg::OP_FIN_RD;
                state_next = S_FWR;
            end
            S_FWR:
            begin
                op         = trwd_pkg::OP_FIN_WR;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                op = trwd_pkg::OP_EVAL;
                if (status.abort_cond)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = status.total_ge ? S_SRD : S_STALL;
                end
            end
            S_SRD:
            begin
                op         = trwd_pkg::OP_SRD;
                state_next = S_SWR;
            end
            S_SWR:
            begin
                op         = trwd_pkg::OP_SWR;
                state_next = status.smore ? S_SRD : S_STALL;
            end
            S_STALL:
            begin
                op         = trwd_pkg::OP_STALL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    op         = trwd_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/transfer_rate_watchdog.sv =====
// ----------------------------------------------------------------------------
// transfer_rate_watchdog: low-speed transfer watchdog
// Phase events go through the load, the phase handling and the result hand-off;
// data events add the seconds scaling, a bucket read and write per skipped
// second, the 40-step wrap divider when the skip wraps the window, the bucket
// refill, the evaluation and a read and write per bucket searched. A first data
// event goes from the seconds step to the hand-off, a same-second one after one
// bucket update. One transaction at a time; the next waits until the result is issued.
// Reset clears all state at once.
// ----------------------------------------------------------------------------
module transfer_rate_watchdog #(
    parameter int MAX_WINDOW = trwd_pkg::MAX_WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // now_ticks[39:0], byte_count[63:40]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // abort_slow[0], deadline_armed[1],
                                   // stall_deadline[41:2], upload_closed_now[42]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    trwd_pkg::status_t status;
    trwd_pkg::op_t     op;

    assign cfg_ready = 1'b1;

    trwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    trwd_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .status    (status)
    );

endmodule
